/* rtl/core/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and codes for the shader source tokenizer: scanner modes,
// token kinds, marks, character codes and the result bundle format.
// ----------------------------------------------------------------------------
package sst_pkg;

    // most results a single source byte can cause
    localparam int SST_MAX_RES     = 4;
    localparam int SST_RES_IDX_W   = 2;
    localparam int SST_QUEUE_DEPTH = 4;

    // commands
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // token kinds
    localparam logic [1:0] KIND_IDENT    = 2'd0;
    localparam logic [1:0] KIND_NUMBER   = 2'd1;
    localparam logic [1:0] KIND_STRING   = 2'd2;
    localparam logic [1:0] KIND_OPERATOR = 2'd3;

    // marks
    localparam logic [1:0] MARK_CHAR   = 2'd0;
    localparam logic [1:0] MARK_END    = 2'd1;
    localparam logic [1:0] MARK_CANCEL = 2'd2;

    // character codes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_IDENT   = 7'b0000010,
        MODE_INT     = 7'b0000100,
        MODE_DOT     = 7'b0001000,
        MODE_FRAC    = 7'b0010000,
        MODE_STRING  = 7'b0100000,
        MODE_COMMENT = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic [1:0] mark;
    } t_res;

    // all results of one source byte; last is the index of the final one
    typedef struct packed {
        t_res [SST_MAX_RES-1:0]     res;
        logic [SST_RES_IDX_W-1:0]   last;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* rtl/core/sst_front.sv */
// ----------------------------------------------------------------------------
// sst_front
// Takes source bytes, steps the scanner mode and builds the bundle of
// results that each byte causes.
// ----------------------------------------------------------------------------
module sst_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_command,
    input  logic [7:0]       i_char_code,
    output logic             o_in_stall,
    input  sst_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output sst_pkg::t_bundle o_bundle
);
    import sst_pkg::*;

    t_mode        r_mode;
    t_mode        n_mode;
    t_res [SST_MAX_RES-1:0] ents;
    logic [2:0]   cnt;
    logic         rescan;
    logic         accept;
    logic [7:0]   c;

    function automatic logic is_letter(input logic [7:0] x);
        return (x >= 8'h61 && x <= 8'h7A) || (x >= 8'h41 && x <= 8'h5A) || x == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] x);
        return x >= CH_ZERO && x <= 8'h39;
    endfunction

    function automatic logic is_oper(input logic [7:0] x);
        return x == 8'h3D || x == 8'h2B || x == 8'h2D || x == 8'h7B || x == 8'h7D ||
               x == 8'h28 || x == 8'h29 || x == 8'h2C || x == 8'h3B || x == 8'h3C ||
               x == 8'h3E;
    endfunction

    assign c      = i_char_code;
    assign accept = i_in_valid && !i_q_stat.full;

    always_comb begin
        ents   = '0;
        cnt    = 3'd0;
        rescan = 1'b0;
        n_mode = r_mode;
        if (i_command == CMD_END || c == CH_NL) begin
            n_mode = MODE_IDLE;
            case (r_mode)
                MODE_IDENT: begin
                    ents[0] = '{ch: CH_NUL, kind: KIND_IDENT, mark: MARK_END};
                    cnt     = 3'd1;
                end
                MODE_INT, MODE_FRAC: begin
                    ents[0] = '{ch: CH_NUL, kind: KIND_NUMBER, mark: MARK_END};
                    cnt     = 3'd1;
                end
                MODE_DOT: begin
                    ents[0] = '{ch: CH_ZERO, kind: KIND_NUMBER, mark: MARK_CHAR};
                    ents[1] = '{ch: CH_NUL, kind: KIND_NUMBER, mark: MARK_END};
                    cnt     = 3'd2;
                end
                MODE_STRING: begin
                    ents[0] = '{ch: CH_NUL, kind: KIND_STRING, mark: MARK_CANCEL};
                    cnt     = 3'd1;
                end
                default: begin
                end
            endcase
        end else begin
            case (r_mode)
                MODE_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        ents[0] = '{ch: c, kind: KIND_IDENT, mark: MARK_CHAR};
                        cnt     = 3'd1;
                    end else begin
                        ents[0] = '{ch: CH_NUL, kind: KIND_IDENT, mark: MARK_END};
                        cnt     = 3'd1;
                        rescan  = 1'b1;
                    end
                end
                MODE_INT: begin
                    if (is_digit(c)) begin
                        ents[0] = '{ch: c, kind: KIND_NUMBER, mark: MARK_CHAR};
                        cnt     = 3'd1;
                    end else if (c == CH_DOT) begin
                        ents[0] = '{ch: c, kind: KIND_NUMBER, mark: MARK_CHAR};
                        cnt     = 3'd1;
                        n_mode  = MODE_DOT;
                    end else begin
                        ents[0] = '{ch: CH_NUL, kind: KIND_NUMBER, mark: MARK_END};
                        cnt     = 3'd1;
                        rescan  = 1'b1;
                    end
                end
                MODE_DOT: begin
                    if (is_digit(c)) begin
                        ents[0] = '{ch: c, kind: KIND_NUMBER, mark: MARK_CHAR};
                        cnt     = 3'd1;
                        n_mode  = MODE_FRAC;
                    end else begin
                        // dangling dot: append the zero, close, then rescan
                        ents[0] = '{ch: CH_ZERO, kind: KIND_NUMBER, mark: MARK_CHAR};
                        ents[1] = '{ch: CH_NUL, kind: KIND_NUMBER, mark: MARK_END};
                        cnt     = 3'd2;
                        rescan  = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (is_digit(c)) begin
                        ents[0] = '{ch: c, kind: KIND_NUMBER, mark: MARK_CHAR};
                        cnt     = 3'd1;
                    end else begin
                        ents[0] = '{ch: CH_NUL, kind: KIND_NUMBER, mark: MARK_END};
                        cnt     = 3'd1;
                        rescan  = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        ents[0] = '{ch: CH_NUL, kind: KIND_STRING, mark: MARK_END};
                        cnt     = 3'd1;
                        n_mode  = MODE_IDLE;
                    end else begin
                        ents[0] = '{ch: c, kind: KIND_STRING, mark: MARK_CHAR};
                        cnt     = 3'd1;
                    end
                end
                MODE_COMMENT: begin
                end
                default: begin
                    rescan = 1'b1;
                end
            endcase

            // byte seen afresh from idle, after whatever closed the token
            if (rescan) begin
                n_mode = MODE_IDLE;
                if (is_letter(c)) begin
                    ents[cnt[1:0]] = '{ch: c, kind: KIND_IDENT, mark: MARK_CHAR};
                    cnt            = cnt + 3'd1;
                    n_mode         = MODE_IDENT;
                end else if (is_digit(c)) begin
                    ents[cnt[1:0]] = '{ch: c, kind: KIND_NUMBER, mark: MARK_CHAR};
                    cnt            = cnt + 3'd1;
                    n_mode         = MODE_INT;
                end else if (c == CH_QUOTE) begin
                    n_mode = MODE_STRING;
                end else if (is_oper(c)) begin
                    ents[cnt[1:0]] = '{ch: c, kind: KIND_OPERATOR, mark: MARK_CHAR};
                    cnt            = cnt + 3'd1;
                    ents[cnt[1:0]] = '{ch: CH_NUL, kind: KIND_OPERATOR, mark: MARK_END};
                    cnt            = cnt + 3'd1;
                end else if (c == CH_SLASH) begin
                    n_mode = MODE_COMMENT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (accept) begin
            r_mode <= n_mode;
        end
    end

    assign o_in_stall    = i_q_stat.full;
    assign o_push        = accept && (cnt != 3'd0);
    assign o_bundle.res  = ents;
    assign o_bundle.last = SST_RES_IDX_W'(cnt - 3'd1);

endmodule

/* rtl/core/sst_queue.sv */
// ----------------------------------------------------------------------------
// sst_queue
// Short queue of result bundles between the scanner and the output side.
// ----------------------------------------------------------------------------
module sst_queue #(
    parameter int DEPTH = sst_pkg::SST_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sst_pkg::t_bundle i_data,
    input  logic             i_pop,
    output sst_pkg::t_bundle o_data,
    output sst_pkg::t_q_stat o_stat
);
    import sst_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_bundle            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/sst_back.sv */
// ----------------------------------------------------------------------------
// sst_back
// Unpacks bundles into single result items, one a cycle while the output
// is not stalled, through an output register.
// ----------------------------------------------------------------------------
module sst_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sst_pkg::t_bundle i_data,
    input  sst_pkg::t_q_stat i_q_stat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_token_char,
    output logic [1:0]       o_token_kind,
    output logic [1:0]       o_mark,
    output logic             o_last_of_run
);
    import sst_pkg::*;

    t_bundle                  r_cur;
    logic                     r_cur_valid;
    logic [SST_RES_IDX_W-1:0] r_idx;
    logic                     r_out_valid;
    t_res                     r_out;
    logic                     r_out_last;
    logic                     load;
    logic                     fire;
    logic                     fin;

    assign load  = !r_out_valid || !i_out_stall;
    assign fire  = load && r_cur_valid;
    assign fin   = fire && (r_idx == r_cur.last);
    assign o_pop = !i_q_stat.empty && (!r_cur_valid || fin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cur_valid <= 1'b1;
                r_idx       <= '0;
            end else if (fin) begin
                r_cur_valid <= 1'b0;
            end else if (fire) begin
                r_idx <= r_idx + SST_RES_IDX_W'(1);
            end
            if (load) begin
                r_out_valid <= r_cur_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_data;
        end
        if (fire) begin
            r_out      <= r_cur.res[r_idx];
            r_out_last <= fin;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_token_char  = r_out.ch;
    assign o_token_kind  = r_out.kind;
    assign o_mark        = r_out.mark;
    assign o_last_of_run = r_out_last;

endmodule

/* rtl/core/shader_source_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// shader_source_tokenizer_core
// Results pass the bundle queue, the unpack register and the output register.
// Throughput: one byte a cycle while the bundle queue has room, one result
// item a cycle out while not stalled, so the output port sets the long-run
// rate when bytes cause several results. Reset (synchronous, active low)
// empties the queue and output register and puts the scanner in idle.
// ----------------------------------------------------------------------------
module shader_source_tokenizer_core #(
    parameter int QUEUE_DEPTH = sst_pkg::SST_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_command,
    input  logic [7:0] i_char_code,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_token_char,
    output logic [1:0] o_token_kind,
    output logic [1:0] o_mark,
    output logic       o_last_of_run
);
    import sst_pkg::*;

    t_q_stat q_stat;
    t_bundle push_data;
    t_bundle pop_data;
    logic    push;
    logic    pop;

    sst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .o_in_stall  (o_in_stall),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_bundle    (push_data)
    );

    sst_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_stat  (q_stat)
    );

    sst_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data        (pop_data),
        .i_q_stat      (q_stat),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_token_char  (o_token_char),
        .o_token_kind  (o_token_kind),
        .o_mark        (o_mark),
        .o_last_of_run (o_last_of_run)
    );

endmodule

/* rtl/core/sst_checker.sv */
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks on the tokenizer's result stream.
// ----------------------------------------------------------------------------
module sst_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] o_token_char,
    input  logic [1:0] o_token_kind,
    input  logic [1:0] o_mark,
    input  logic       o_last_of_run
);
    import sst_pkg::*;

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_token_char) &&
        $stable(o_token_kind) && $stable(o_mark) && $stable(o_last_of_run))
        else $error("stalled result item changed");

    // end and cancel marks carry no character
    a_mark_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mark != MARK_CHAR |-> o_token_char == CH_NUL)
        else $error("mark item with a character");

    // only a string is cancelled, and nothing follows it for that byte
    a_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mark == MARK_CANCEL |-> o_token_kind == KIND_STRING && o_last_of_run)
        else $error("bad cancel item");

    // an operator character is always followed by its end mark from the same byte
    a_oper_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mark == MARK_CHAR && o_token_kind == KIND_OPERATOR |-> !o_last_of_run)
        else $error("operator without end mark");

endmodule

bind shader_source_tokenizer_core sst_checker u_sst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_token_char  (o_token_char),
    .o_token_kind  (o_token_kind),
    .o_mark        (o_mark),
    .o_last_of_run (o_last_of_run)
);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for shader_source_tokenizer_core. A short table of
// source bytes covers the token kinds, the number and string repairs and
// the comment and skip rules. Shader-like random text follows. Every token
// item that comes out is compared against typed rows or an in-bench scanner model.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int RAND_ITEMS   = 93;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic [1:0] mark;
        logic       last;
    } t_token;

    // n_typed < 0: results come from the scanner model
    typedef struct {
        logic       cmd;
        logic [7:0] ch;
        int         n_typed;
        t_res       r0;
        t_res       r1;
    } t_script_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic       i_command = CMD_BYTE;
    logic [7:0] i_char_code = CH_NUL;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_token_char;
    logic [1:0] o_token_kind;
    logic [1:0] o_mark;
    logic       o_last_of_run;

    t_token      expected_tokens[$];
    t_token      step_tokens[$];
    t_script_row script_rows[$];
    t_mode       scan_state = MODE_IDLE;

    bit no_idle = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    int errors = 0;
    int cycles = 0;
    int bytes_sent = 0;
    int useful_bytes = 0;
    int tokens_checked = 0;
    int cancels_seen = 0;
    int max_burst = 0;

    shader_source_tokenizer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_char_code   (i_char_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_token_char  (o_token_char),
        .o_token_kind  (o_token_kind),
        .o_mark        (o_mark),
        .o_last_of_run (o_last_of_run)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d token items still awaited", $time,
                     expected_tokens.size());
            $display("shader_source_tokenizer_core verification failed");
            $finish;
        end
    end

    // ---------------- scanner model ----------------

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    function automatic bit is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_op_char(input logic [7:0] c);
        case (c)
            "=", "+", "-", "{", "}", "(", ")", ",", ";", "<", ">": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void emit(input logic [7:0] ch, input logic [1:0] kind,
                                 input logic [1:0] mark);
        t_token tok;
        tok = {ch, kind, mark, 1'b0};
        step_tokens.push_back(tok);
    endfunction

    function automatic void scan_from_idle(input logic [7:0] c);
        scan_state = MODE_IDLE;
        if (is_alpha(c)) begin
            emit(c, KIND_IDENT, MARK_CHAR);
            scan_state = MODE_IDENT;
        end else if (is_num(c)) begin
            emit(c, KIND_NUMBER, MARK_CHAR);
            scan_state = MODE_INT;
        end else if (c == CH_QUOTE) begin
            scan_state = MODE_STRING;
        end else if (is_op_char(c)) begin
            emit(c, KIND_OPERATOR, MARK_CHAR);
            emit(CH_NUL, KIND_OPERATOR, MARK_END);
        end else if (c == CH_SLASH) begin
            scan_state = MODE_COMMENT;
        end
    endfunction

    // line end or end of source closes whatever is open
    function automatic void close_line();
        case (scan_state)
            MODE_IDENT: emit(CH_NUL, KIND_IDENT, MARK_END);
            MODE_INT, MODE_FRAC: emit(CH_NUL, KIND_NUMBER, MARK_END);
            MODE_DOT: begin
                emit(CH_ZERO, KIND_NUMBER, MARK_CHAR);
                emit(CH_NUL, KIND_NUMBER, MARK_END);
            end
            MODE_STRING: emit(CH_NUL, KIND_STRING, MARK_CANCEL);
            default: ;
        endcase
        scan_state = MODE_IDLE;
    endfunction

    function automatic void scan_byte(input logic cmd, input logic [7:0] c);
        step_tokens.delete();
        if (cmd == CMD_END || c == CH_NL) begin
            close_line();
        end else begin
            case (scan_state)
                MODE_IDENT: begin
                    if (is_alpha(c) || is_num(c)) begin
                        emit(c, KIND_IDENT, MARK_CHAR);
                    end else begin
                        emit(CH_NUL, KIND_IDENT, MARK_END);
                        scan_from_idle(c);
                    end
                end
                MODE_INT: begin
                    if (is_num(c)) begin
                        emit(c, KIND_NUMBER, MARK_CHAR);
                    end else if (c == CH_DOT) begin
                        emit(c, KIND_NUMBER, MARK_CHAR);
                        scan_state = MODE_DOT;
                    end else begin
                        emit(CH_NUL, KIND_NUMBER, MARK_END);
                        scan_from_idle(c);
                    end
                end
                MODE_DOT: begin
                    if (is_num(c)) begin
                        emit(c, KIND_NUMBER, MARK_CHAR);
                        scan_state = MODE_FRAC;
                    end else begin
                        emit(CH_ZERO, KIND_NUMBER, MARK_CHAR);
                        emit(CH_NUL, KIND_NUMBER, MARK_END);
                        scan_from_idle(c);
                    end
                end
                MODE_FRAC: begin
                    if (is_num(c)) begin
                        emit(c, KIND_NUMBER, MARK_CHAR);
                    end else begin
                        emit(CH_NUL, KIND_NUMBER, MARK_END);
                        scan_from_idle(c);
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        emit(CH_NUL, KIND_STRING, MARK_END);
                        scan_state = MODE_IDLE;
                    end else begin
                        emit(c, KIND_STRING, MARK_CHAR);
                    end
                end
                MODE_COMMENT: ;
                default: scan_from_idle(c);
            endcase
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
    endfunction

    // ---------------- stimulus ----------------

    function automatic t_res tok_res(input logic [7:0] ch, input logic [1:0] kind,
                                     input logic [1:0] mark);
        return {ch, kind, mark};
    endfunction

    function automatic void add_row(input logic cmd, input logic [7:0] ch,
                                    input int n_typed = -1,
                                    input t_res r0 = '0, input t_res r1 = '0);
        t_script_row row;
        row.cmd     = cmd;
        row.ch      = ch;
        row.n_typed = n_typed;
        row.r0      = r0;
        row.r1      = r1;
        script_rows.push_back(row);
    endfunction

    // shader-like text: mostly names, numbers and operators, some noise
    function automatic void pick_source(output logic cmd, output logic [7:0] ch);
        int    r;
        int    k;
        string op_set;
        op_set = "=+-{}(),;<>";
        r   = $urandom_range(0, 99);
        cmd = CMD_BYTE;
        if (r < 28) begin
            k = $urandom_range(0, 52);
            if (k < 26) ch = 8'("a" + k);
            else if (k < 52) ch = 8'("A" + k - 26);
            else ch = CH_UNDER;
        end else if (r < 46) begin
            ch = 8'("0" + $urandom_range(0, 9));
        end else if (r < 53) begin
            ch = CH_DOT;
        end else if (r < 66) begin
            ch = op_set[$urandom_range(0, op_set.len() - 1)];
        end else if (r < 71) begin
            ch = CH_QUOTE;
        end else if (r < 74) begin
            ch = CH_SLASH;
        end else if (r < 80) begin
            ch = CH_NL;
        end else if (r < 87) begin
            ch = " ";
        end else if (r < 90) begin
            cmd = CMD_END;
            ch  = 8'($urandom_range(0, 255));
        end else begin
            ch = 8'($urandom_range(0, 255));
        end
    endfunction

    // offer one item, hold it until taken, then step the scanner model
    task automatic feed(input logic cmd, input logic [7:0] ch, input bit use_model);
        t_mode prior;
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_char_code <= ch;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        prior = scan_state;
        scan_byte(cmd, ch);
        bytes_sent++;
        if (step_tokens.size() > 0 || scan_state != prior) useful_bytes++;
        if (step_tokens.size() > max_burst) max_burst = step_tokens.size();
        if (use_model) begin
            foreach (step_tokens[j]) expected_tokens.push_back(step_tokens[j]);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_tokens.size() != 0);
    endtask

    initial begin
        t_token     tok;
        logic       cmd;
        logic [7:0] ch;

        add_row(CMD_END, 8'hA5, 0);
        add_row(CMD_BYTE, "=", 2, tok_res("=", KIND_OPERATOR, MARK_CHAR),
                tok_res(CH_NUL, KIND_OPERATOR, MARK_END));
        add_row(CMD_BYTE, 8'h80, 0);
        add_row(CMD_BYTE, CH_UNDER);
        add_row(CMD_BYTE, "Z");
        add_row(CMD_BYTE, "9");
        add_row(CMD_BYTE, "(");
        // dot then operator gives the full four items
        add_row(CMD_BYTE, "0");
        add_row(CMD_BYTE, CH_DOT);
        add_row(CMD_BYTE, "=");
        add_row(CMD_BYTE, "4");
        add_row(CMD_BYTE, CH_DOT);
        add_row(CMD_BYTE, "2");
        add_row(CMD_BYTE, CH_NL);
        add_row(CMD_BYTE, "7");
        add_row(CMD_BYTE, CH_DOT);
        add_row(CMD_END, CH_NUL);
        add_row(CMD_BYTE, CH_QUOTE, 0);
        add_row(CMD_BYTE, 8'hFF);
        add_row(CMD_BYTE, 8'h00);
        add_row(CMD_BYTE, CH_QUOTE, 1, tok_res(CH_NUL, KIND_STRING, MARK_END));
        add_row(CMD_BYTE, CH_QUOTE, 0);
        add_row(CMD_BYTE, CH_NL, 1, tok_res(CH_NUL, KIND_STRING, MARK_CANCEL));
        add_row(CMD_BYTE, "a");
        add_row(CMD_BYTE, CH_SLASH);
        add_row(CMD_BYTE, "z", 0);
        add_row(CMD_BYTE, CH_NL, 0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script_rows[k]) begin
            feed(script_rows[k].cmd, script_rows[k].ch, script_rows[k].n_typed < 0);
            for (int j = 0; j < script_rows[k].n_typed; j++) begin
                tok = {(j == 0) ? script_rows[k].r0 : script_rows[k].r1,
                       j == script_rows[k].n_typed - 1};
                expected_tokens.push_back(tok);
            end
        end
        drain();

        // long output hold while the sender keeps going
        hold_request <= 1'b1;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == 25) no_idle <= 1'b1;
            if (n == 55) no_idle <= 1'b0;
            if (n == 70) drain();
            pick_source(cmd, ch);
            feed(cmd, ch, 1'b1);
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (expected_tokens.size() != 0) begin
            $display("%0t: %0d token items never arrived", $time, expected_tokens.size());
            errors++;
        end
        $display("covered %0d source items (%0d touched a token), %0d token items checked,",
                 bytes_sent, useful_bytes, tokens_checked);
        $display("%0d cancels, bursts of up to %0d items per byte, one %0d-cycle output hold",
                 cancels_seen, max_burst, HOLD_CYCLES);
        if (errors == 0) begin
            $display("shader_source_tokenizer_core verification clean");
        end else begin
            $display("shader_source_tokenizer_core verification failed");
        end
        $finish;
    end

    // ---------------- result side ----------------

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected item, expected none got char %0d kind %0d mark %0d",
                         $time, o_token_char, o_token_kind, o_mark);
                errors++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_char", want.ch, o_token_char);
                check_field("token_kind", 8'(want.kind), 8'(o_token_kind));
                check_field("mark", 8'(want.mark), 8'(o_mark));
                check_field("last_of_run", 8'(want.last), 8'(o_last_of_run));
                tokens_checked++;
                if (o_mark == MARK_CANCEL) cancels_seen++;
            end
        end
    end

    // receiver stalls: random idling, plus one long hold counted here
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_done   <= 1'b1;
        end else begin
            i_out_stall <= !no_idle && ($urandom_range(0, 99) < 13);
        end
    end

endmodule

/* shader_source_tokenizer_core.f */
rtl/core/sst_pkg.sv
rtl/core/sst_front.sv
rtl/core/sst_queue.sv
rtl/core/sst_back.sv
rtl/core/shader_source_tokenizer_core.sv
rtl/core/sst_checker.sv
bench/tb_top.sv
